[rtl/llgi_pkg.sv]
// Package for the lat/lon grid cell indexer: commands, cell size tables,
// reciprocal tables and the job record that travels down the pipeline.
// No dependencies.
package llgi_pkg;

    typedef enum logic [1:0] {
        CMD_ENCODE    = 2'd0,
        CMD_DECODE    = 2'd1,
        CMD_NEIGHBORS = 2'd2,
        CMD_ADJACENT  = 2'd3
    } cmd_t;

    localparam int SIZE_W    = 26;
    localparam int WIDE_W    = 59;
    localparam int LAT_OFF_W = 31;
    localparam int LON_OFF_W = 32;
    localparam int QUOT_W    = 28;
    localparam int CLAT_W    = 56;
    localparam int CLON_W    = 57;
    localparam int ID_W      = 63;

    localparam logic [WIDE_W-1:0] LAT_HALF   = 59'd900000000;
    localparam logic [WIDE_W-1:0] LAT_SPAN   = 59'd1800000000;
    localparam logic [WIDE_W-1:0] LON_HALF   = 59'd1800000000;
    localparam logic [WIDE_W-1:0] LON_WIDE_P = 59'd3600000000;
    localparam logic [31:0]       LON_PERIOD = 32'd3600000000;
    localparam logic [34:0]       LON_P1     = 35'd3600000000;
    localparam logic [34:0]       LON_P2     = 35'd7200000000;

    // floor(2^56 / 3600000000), quotient estimate for the longitude fold
    localparam logic [24:0] FOLD_RECIP = 25'((64'd1 << 56) / 64'd3600000000);

    localparam logic [SIZE_W-1:0] CELL_SIZE [16] = '{
        26'd40000000, 26'd15000000, 26'd5000000, 26'd1700000,
        26'd600000,   26'd200000,   26'd70000,   26'd25000,
        26'd9000,     26'd15700,    26'd5500,    26'd2000,
        26'd700,      26'd250,      26'd90,      26'd30
    };

    // shift = 32 + floor(log2(size)), recip = floor(2^shift / size)
    localparam logic [5:0] DIV_SHIFT [16] = '{
        6'd57, 6'd55, 6'd54, 6'd52, 6'd51, 6'd49, 6'd48, 6'd46,
        6'd45, 6'd45, 6'd44, 6'd42, 6'd41, 6'd39, 6'd38, 6'd36
    };

    localparam logic [31:0] DIV_RECIP [16] = '{
        32'((64'd1 << 57) / 64'd40000000), 32'((64'd1 << 55) / 64'd15000000),
        32'((64'd1 << 54) / 64'd5000000),  32'((64'd1 << 52) / 64'd1700000),
        32'((64'd1 << 51) / 64'd600000),   32'((64'd1 << 49) / 64'd200000),
        32'((64'd1 << 48) / 64'd70000),    32'((64'd1 << 46) / 64'd25000),
        32'((64'd1 << 45) / 64'd9000),     32'((64'd1 << 45) / 64'd15700),
        32'((64'd1 << 44) / 64'd5500),     32'((64'd1 << 42) / 64'd2000),
        32'((64'd1 << 41) / 64'd700),      32'((64'd1 << 39) / 64'd250),
        32'((64'd1 << 38) / 64'd90),       32'((64'd1 << 36) / 64'd30)
    };

    typedef struct packed {
        cmd_t                     cmd;
        logic [3:0]               level;
        logic                     last;
        logic                     emit;
        logic                     ne;
        logic [63:0]              cell_b;
        logic signed [CLAT_W-1:0] clat;
        logic signed [CLON_W-1:0] clon;
    } job_t;

    typedef struct packed {
        logic signed [1:0] dy;
        logic signed [1:0] dx;
    } step_t;

    // neighbor offsets in row order, center skipped
    function automatic step_t nb_step(input logic [2:0] n);
        step_t s;
        unique case (n)
            3'd0: s = '{dy: -2'sd1, dx: -2'sd1};
            3'd1: s = '{dy: -2'sd1, dx:  2'sd0};
            3'd2: s = '{dy: -2'sd1, dx:  2'sd1};
            3'd3: s = '{dy:  2'sd0, dx: -2'sd1};
            3'd4: s = '{dy:  2'sd0, dx:  2'sd1};
            3'd5: s = '{dy:  2'sd1, dx: -2'sd1};
            3'd6: s = '{dy:  2'sd1, dx:  2'sd0};
            default: s = '{dy: 2'sd1, dx: 2'sd1};
        endcase
        return s;
    endfunction

endpackage

[rtl/llgi_front.sv]
// Input holding register, neighbor sequencer, centre products and offsets.
// Depends on llgi_pkg.
module llgi_front
    import llgi_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  cmd_t                 up_cmd,
    input  logic [31:0]          up_lat,
    input  logic [31:0]          up_lon,
    input  logic [3:0]           up_level,
    input  logic [63:0]          up_cell_a,
    input  logic [63:0]          up_cell_b,
    output logic                 dn_valid,
    input  logic                 dn_ready,
    output job_t                 dn_job,
    output logic [LAT_OFF_W-1:0] dn_lat_off,
    output logic [WIDE_W-1:0]    dn_lon_raw
);

    logic        hold_v_reg, hold_v_next;
    logic [2:0]  cnt_reg, cnt_next;
    cmd_t        h_cmd_reg;
    logic [31:0] h_lat_reg, h_lon_reg;
    logic [3:0]  h_level_reg;
    logic [63:0] h_a_reg, h_b_reg;

    logic f1_v_reg, f2_v_reg, f3_v_reg;
    logic en1, en2, en3;

    job_t               f1_job_reg, f1_job_next, f2_job_reg, f3_job_reg, f3_job_next;
    logic signed [30:0] f1_lat_i_reg, f1_lat_i_next;
    logic signed [31:0] f1_lon_i_reg, f1_lon_i_next;
    logic [SIZE_W-1:0]  f1_size_reg, f2_size_reg;
    logic [31:0]        f1_lat_reg, f1_lon_reg, f2_lat_reg, f2_lon_reg;
    logic signed [57:0] f2_plat_reg, f2_plat_next;
    logic signed [58:0] f2_plon_reg, f2_plon_next;
    logic [LAT_OFF_W-1:0] f3_a_reg, f3_a_next;
    logic [WIDE_W-1:0]  f3_o_reg, f3_o_next;

    logic        use_nb, grp_last, issue, take;
    step_t       step;
    logic signed [1:0] dy, dx;
    logic [3:0]  lvl;
    logic [SIZE_W-1:0] half;
    logic [WIDE_W-1:0] lat_raw, lon_raw;

    assign en3 = !f3_v_reg || dn_ready;
    assign en2 = !f2_v_reg || en3;
    assign en1 = !f1_v_reg || en2;

    always_comb
    begin
        use_nb   = (h_cmd_reg == CMD_NEIGHBORS) || (h_cmd_reg == CMD_ADJACENT);
        grp_last = !use_nb || (cnt_reg == 3'd7);
        step     = nb_step(cnt_reg);
        dy       = use_nb ? step.dy : 2'sd0;
        dx       = use_nb ? step.dx : 2'sd0;
        issue    = hold_v_reg && en1;
        up_ready = !hold_v_reg || (issue && grp_last);
        take     = up_valid && up_ready;

        hold_v_next = hold_v_reg;
        cnt_next    = cnt_reg;
        if (take)
        begin
            hold_v_next = 1'b1;
            cnt_next    = 3'd0;
        end
        else if (issue && grp_last)
        begin
            hold_v_next = 1'b0;
        end
        else if (issue)
        begin
            cnt_next = cnt_reg + 3'd1;
        end

        lvl = (h_cmd_reg == CMD_ENCODE) ? h_level_reg : h_a_reg[62:59];
        f1_job_next        = '0;
        f1_job_next.cmd    = h_cmd_reg;
        f1_job_next.level  = lvl;
        f1_job_next.last   = grp_last;
        f1_job_next.emit   = (h_cmd_reg != CMD_ADJACENT) || grp_last;
        f1_job_next.ne     = (h_a_reg != h_b_reg);
        f1_job_next.cell_b = h_b_reg;
        f1_lat_i_next = $signed({2'b00, h_a_reg[28:0]}) + $signed({{29{dy[1]}}, dy});
        f1_lon_i_next = $signed({2'b00, h_a_reg[58:29]}) + $signed({{30{dx[1]}}, dx});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_v_reg <= 1'b0;
            cnt_reg    <= 3'd0;
            f1_v_reg   <= 1'b0;
            f2_v_reg   <= 1'b0;
            f3_v_reg   <= 1'b0;
        end
        else
        begin
            hold_v_reg <= hold_v_next;
            cnt_reg    <= cnt_next;
            if (en1)
                f1_v_reg <= hold_v_reg;
            if (en2)
                f2_v_reg <= f1_v_reg;
            if (en3)
                f3_v_reg <= f2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            h_cmd_reg   <= up_cmd;
            h_lat_reg   <= up_lat;
            h_lon_reg   <= up_lon;
            h_level_reg <= up_level;
            h_a_reg     <= up_cell_a;
            h_b_reg     <= up_cell_b;
        end
        if (en1)
        begin
            f1_job_reg   <= f1_job_next;
            f1_lat_i_reg <= f1_lat_i_next;
            f1_lon_i_reg <= f1_lon_i_next;
            f1_size_reg  <= CELL_SIZE[lvl];
            f1_lat_reg   <= h_lat_reg;
            f1_lon_reg   <= h_lon_reg;
        end
        if (en2)
        begin
            f2_job_reg  <= f1_job_reg;
            f2_plat_reg <= f2_plat_next;
            f2_plon_reg <= f2_plon_next;
            f2_size_reg <= f1_size_reg;
            f2_lat_reg  <= f1_lat_reg;
            f2_lon_reg  <= f1_lon_reg;
        end
        if (en3)
        begin
            f3_job_reg <= f3_job_next;
            f3_a_reg   <= f3_a_next;
            f3_o_reg   <= f3_o_next;
        end
    end

    always_comb
    begin
        f2_plat_next = f1_lat_i_reg * $signed({1'b0, f1_size_reg});
        f2_plon_next = f1_lon_i_reg * $signed({1'b0, f1_size_reg});
    end

    always_comb
    begin
        half = {1'b0, f2_size_reg[SIZE_W-1:1]};
        if (f2_job_reg.cmd == CMD_ENCODE)
        begin
            lat_raw = {{27{f2_lat_reg[31]}}, f2_lat_reg} + LAT_HALF;
            lon_raw = {{27{f2_lon_reg[31]}}, f2_lon_reg} + LON_HALF;
        end
        else
        begin
            lat_raw = {f2_plat_reg[57], f2_plat_reg} + {33'd0, half};
            lon_raw = f2_plon_reg + {33'd0, half};
        end

        if (lat_raw[WIDE_W-1])
            f3_a_next = '0;
        else if (lat_raw > LAT_SPAN)
            f3_a_next = LAT_OFF_W'(LAT_SPAN);
        else
            f3_a_next = lat_raw[LAT_OFF_W-1:0];
        f3_o_next = lon_raw;

        f3_job_next = f2_job_reg;
        if (f2_job_reg.cmd == CMD_DECODE)
        begin
            f3_job_next.clat = CLAT_W'(lat_raw - LAT_HALF);
            f3_job_next.clon = CLON_W'(lon_raw - LON_HALF);
        end
    end

    assign dn_valid   = f3_v_reg;
    assign dn_job     = f3_job_reg;
    assign dn_lat_off = f3_a_reg;
    assign dn_lon_raw = f3_o_reg;

endmodule

[rtl/llgi_fold.sv]
// Longitude fold into one period: reciprocal quotient estimate, remainder
// and correction over five stages. Depends on llgi_pkg.
module llgi_fold
    import llgi_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  job_t                 up_job,
    input  logic [LAT_OFF_W-1:0] up_lat_off,
    input  logic [WIDE_W-1:0]    up_lon_raw,
    output logic                 dn_valid,
    input  logic                 dn_ready,
    output job_t                 dn_job,
    output logic [LAT_OFF_W-1:0] dn_lat_off,
    output logic [LON_OFF_W-1:0] dn_lon_off
);

    logic [4:0] v_reg;
    logic [4:0] en;

    job_t                 job_reg [5];
    logic [LAT_OFF_W-1:0] a_reg [5];
    logic                 big_reg [4];
    logic [31:0]          s_reg [4];

    logic [55:0] d0_y_reg, d0_y_next;
    logic        d0_big_next;
    logic [31:0] d0_s_next;
    logic [56:0] d1_mulq_reg, d1_mulq_next;
    logic [34:0] d1_y_reg;
    logic [34:0] d2_prod_reg, d2_prod_next;
    logic [34:0] d2_y_reg;
    logic [34:0] d3_r_reg, d3_r_next;
    logic [31:0] d4_b_reg, d4_b_next;
    logic [24:0] qe;
    logic [34:0] rr;

    assign en[4] = !v_reg[4] || dn_ready;
    assign en[3] = !v_reg[3] || en[4];
    assign en[2] = !v_reg[2] || en[3];
    assign en[1] = !v_reg[1] || en[2];
    assign en[0] = !v_reg[0] || en[1];
    assign up_ready = en[0];

    always_comb
    begin
        d0_big_next = !up_lon_raw[WIDE_W-1] && (up_lon_raw > LON_WIDE_P);
        d0_y_next   = 56'(up_lon_raw - 59'd1);
        d0_s_next   = up_lon_raw[WIDE_W-1] ? 32'(up_lon_raw + LON_WIDE_P)
                                           : up_lon_raw[31:0];
        d1_mulq_next = d0_y_reg[55:24] * FOLD_RECIP;
        qe           = d1_mulq_reg[56:32];
        d2_prod_next = qe * LON_PERIOD;
        d3_r_next    = d2_y_reg - d2_prod_reg;
        if (d3_r_reg >= LON_P2)
            rr = d3_r_reg - LON_P2;
        else if (d3_r_reg >= LON_P1)
            rr = d3_r_reg - LON_P1;
        else
            rr = d3_r_reg;
        d4_b_next = big_reg[3] ? (rr[31:0] + 32'd1) : s_reg[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (en[0]) v_reg[0] <= up_valid;
            if (en[1]) v_reg[1] <= v_reg[0];
            if (en[2]) v_reg[2] <= v_reg[1];
            if (en[3]) v_reg[3] <= v_reg[2];
            if (en[4]) v_reg[4] <= v_reg[3];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            job_reg[0] <= up_job;
            a_reg[0]   <= up_lat_off;
            big_reg[0] <= d0_big_next;
            s_reg[0]   <= d0_s_next;
            d0_y_reg   <= d0_y_next;
        end
        if (en[1])
        begin
            job_reg[1]  <= job_reg[0];
            a_reg[1]    <= a_reg[0];
            big_reg[1]  <= big_reg[0];
            s_reg[1]    <= s_reg[0];
            d1_mulq_reg <= d1_mulq_next;
            d1_y_reg    <= d0_y_reg[34:0];
        end
        if (en[2])
        begin
            job_reg[2]  <= job_reg[1];
            a_reg[2]    <= a_reg[1];
            big_reg[2]  <= big_reg[1];
            s_reg[2]    <= s_reg[1];
            d2_prod_reg <= d2_prod_next;
            d2_y_reg    <= d1_y_reg;
        end
        if (en[3])
        begin
            job_reg[3] <= job_reg[2];
            a_reg[3]   <= a_reg[2];
            big_reg[3] <= big_reg[2];
            s_reg[3]   <= s_reg[2];
            d3_r_reg   <= d3_r_next;
        end
        if (en[4])
        begin
            job_reg[4] <= job_reg[3];
            a_reg[4]   <= a_reg[3];
            d4_b_reg   <= d4_b_next;
        end
    end

    assign dn_valid   = v_reg[4];
    assign dn_job     = job_reg[4];
    assign dn_lat_off = a_reg[4];
    assign dn_lon_off = d4_b_reg;

endmodule

[rtl/llgi_div.sv]
// Division of both offsets by the level's cell size: reciprocal product,
// shift, back-multiply, one-step correction and cell id packing.
// Depends on llgi_pkg.
module llgi_div
    import llgi_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  job_t                 up_job,
    input  logic [LAT_OFF_W-1:0] up_lat_off,
    input  logic [LON_OFF_W-1:0] up_lon_off,
    output logic                 dn_valid,
    input  logic                 dn_ready,
    output job_t                 dn_job,
    output logic [ID_W-1:0]      dn_id
);

    logic [3:0] v_reg;
    logic [3:0] en;

    job_t                 job_reg [4];
    logic [LAT_OFF_W-1:0] a_reg [3];
    logic [LON_OFF_W-1:0] b_reg [3];

    logic [62:0]       pa_reg, pa_next;
    logic [63:0]       pb_reg, pb_next;
    logic [QUOT_W-1:0] qa_reg [2];
    logic [QUOT_W-1:0] qb_reg [2];
    logic [QUOT_W-1:0] qa_next, qb_next;
    logic [32:0]       ca_reg, ca_next, cb_reg, cb_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [32:0]       ra, rb;
    logic [QUOT_W-1:0] qa_fin, qb_fin;
    logic [SIZE_W-1:0] sz2, sz3;

    assign en[3] = !v_reg[3] || dn_ready;
    assign en[2] = !v_reg[2] || en[3];
    assign en[1] = !v_reg[1] || en[2];
    assign en[0] = !v_reg[0] || en[1];
    assign up_ready = en[0];

    always_comb
    begin
        pa_next = up_lat_off * DIV_RECIP[up_job.level];
        pb_next = up_lon_off * DIV_RECIP[up_job.level];
        qa_next = QUOT_W'(pa_reg >> DIV_SHIFT[job_reg[0].level]);
        qb_next = QUOT_W'(pb_reg >> DIV_SHIFT[job_reg[0].level]);
        sz2     = CELL_SIZE[job_reg[1].level];
        ca_next = qa_reg[0] * sz2;
        cb_next = qb_reg[0] * sz2;
        sz3     = CELL_SIZE[job_reg[2].level];
        ra      = {2'b00, a_reg[2]} - ca_reg;
        rb      = {1'b0, b_reg[2]} - cb_reg;
        qa_fin  = (ra >= {7'd0, sz3}) ? (qa_reg[1] + 1'b1) : qa_reg[1];
        qb_fin  = (rb >= {7'd0, sz3}) ? (qb_reg[1] + 1'b1) : qb_reg[1];
        // quotients never reach bit 28, upper index bits are zero
        id_next = {job_reg[2].level, 2'b00, qb_fin, 1'b0, qa_fin};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (en[0]) v_reg[0] <= up_valid;
            if (en[1]) v_reg[1] <= v_reg[0];
            if (en[2]) v_reg[2] <= v_reg[1];
            if (en[3]) v_reg[3] <= v_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            job_reg[0] <= up_job;
            a_reg[0]   <= up_lat_off;
            b_reg[0]   <= up_lon_off;
            pa_reg     <= pa_next;
            pb_reg     <= pb_next;
        end
        if (en[1])
        begin
            job_reg[1] <= job_reg[0];
            a_reg[1]   <= a_reg[0];
            b_reg[1]   <= b_reg[0];
            qa_reg[0]  <= qa_next;
            qb_reg[0]  <= qb_next;
        end
        if (en[2])
        begin
            job_reg[2] <= job_reg[1];
            a_reg[2]   <= a_reg[1];
            b_reg[2]   <= b_reg[1];
            qa_reg[1]  <= qa_reg[0];
            qb_reg[1]  <= qb_reg[0];
            ca_reg     <= ca_next;
            cb_reg     <= cb_next;
        end
        if (en[3])
        begin
            job_reg[3] <= job_reg[2];
            id_reg     <= id_next;
        end
    end

    assign dn_valid = v_reg[3];
    assign dn_job   = job_reg[3];
    assign dn_id    = id_reg;

endmodule

[rtl/llgi_out.sv]
// Adjacency accumulation over the eight neighbor jobs and the output
// register with result field selection. Depends on llgi_pkg.
module llgi_out
    import llgi_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     up_valid,
    output logic                     up_ready,
    input  job_t                     up_job,
    input  logic [ID_W-1:0]          up_id,
    output logic                     dn_valid,
    input  logic                     dn_ready,
    output logic [ID_W-1:0]          dn_cell_id,
    output logic signed [CLAT_W-1:0] dn_clat,
    output logic signed [CLON_W-1:0] dn_clon,
    output logic [3:0]               dn_level,
    output logic                     dn_adjacent,
    output logic                     dn_last
);

    logic ov_reg, ov_next;
    logic acc_reg, acc_next;
    logic match, consume, load;

    cmd_t                     cmd_reg;
    logic [ID_W-1:0]          id_reg, id_next;
    logic signed [CLAT_W-1:0] clat_reg;
    logic signed [CLON_W-1:0] clon_reg;
    logic [3:0]               level_reg;
    logic                     adj_reg, adj_next;
    logic                     last_reg;

    always_comb
    begin
        up_ready = !ov_reg || dn_ready;
        consume  = up_valid && up_ready;
        load     = consume && up_job.emit;
        match    = acc_reg || ({1'b0, up_id} == up_job.cell_b);

        acc_next = acc_reg;
        if (consume && (up_job.cmd == CMD_ADJACENT))
            acc_next = up_job.last ? 1'b0 : match;

        ov_next = up_ready ? load : ov_reg;

        adj_next = (up_job.cmd == CMD_ADJACENT) && up_job.ne && match;
        id_next  = ((up_job.cmd == CMD_ENCODE) || (up_job.cmd == CMD_NEIGHBORS))
                 ? up_id : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg  <= 1'b0;
            acc_reg <= 1'b0;
        end
        else
        begin
            ov_reg  <= ov_next;
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cmd_reg   <= up_job.cmd;
            id_reg    <= id_next;
            clat_reg  <= up_job.clat;
            clon_reg  <= up_job.clon;
            level_reg <= up_job.level;
            adj_reg   <= adj_next;
            last_reg  <= up_job.last;
        end
    end

    assign dn_valid    = ov_reg;
    assign dn_cell_id  = id_reg;
    assign dn_clat     = clat_reg;
    assign dn_clon     = clon_reg;
    assign dn_level    = level_reg;
    assign dn_adjacent = adj_reg;
    assign dn_last     = last_reg;

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && (cmd_reg != CMD_NEIGHBORS)) |-> last_reg)
        else $error("single-result command without last");

    a_adj_only: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && (cmd_reg != CMD_ADJACENT)) |-> !adj_reg)
        else $error("adjacent flag on non-adjacency item");

    a_no_id: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && ((cmd_reg == CMD_DECODE) || (cmd_reg == CMD_ADJACENT)))
        |-> (id_reg == '0))
        else $error("cell id not cleared");

    a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && up_job.last) |=> !acc_reg)
        else $error("adjacency accumulator not cleared after group");

endmodule

[rtl/latlon_grid_cell_indexer.sv]
// Lat/lon square-grid cell indexer, top level. Depends on llgi_pkg and the
// llgi_front, llgi_fold, llgi_div and llgi_out pipeline sections.
// Throughput, while the output is not stalled: one item per cycle for encode
// and decode; neighbor listing and adjacency hold the input stage until all
// their neighbor jobs have issued, one neighbor job per cycle.
// Reset (rst_n low, asynchronous) empties every stage; no warm-up pass.
module latlon_grid_cell_indexer
    import llgi_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // latitude[31:0], longitude[63:32], level[67:64], cell_a[131:68],
    // cell_b[195:132], zero pad
    input  logic [199:0] s_axis_tdata,
    // cmd[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // cell_id[62:0], centre_lat[118:63], centre_lon[175:119],
    // level_out[179:176], adjacent[180], zero pad
    output logic [183:0] m_axis_tdata,
    output logic         m_axis_tlast
);

    logic                 f_valid, f_ready, d_valid, d_ready, v_valid, v_ready;
    job_t                 f_job, d_job, v_job;
    logic [LAT_OFF_W-1:0] f_lat_off, d_lat_off;
    logic [WIDE_W-1:0]    f_lon_raw;
    logic [LON_OFF_W-1:0] d_lon_off;
    logic [ID_W-1:0]      v_id, o_id;
    logic signed [CLAT_W-1:0] o_clat;
    logic signed [CLON_W-1:0] o_clon;
    logic [3:0]           o_level;
    logic                 o_adj;

    llgi_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (s_axis_tvalid),
        .up_ready   (s_axis_tready),
        .up_cmd     (cmd_t'(s_axis_tuser)),
        .up_lat     (s_axis_tdata[31:0]),
        .up_lon     (s_axis_tdata[63:32]),
        .up_level   (s_axis_tdata[67:64]),
        .up_cell_a  (s_axis_tdata[131:68]),
        .up_cell_b  (s_axis_tdata[195:132]),
        .dn_valid   (f_valid),
        .dn_ready   (f_ready),
        .dn_job     (f_job),
        .dn_lat_off (f_lat_off),
        .dn_lon_raw (f_lon_raw)
    );

    llgi_fold u_fold (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (f_valid),
        .up_ready   (f_ready),
        .up_job     (f_job),
        .up_lat_off (f_lat_off),
        .up_lon_raw (f_lon_raw),
        .dn_valid   (d_valid),
        .dn_ready   (d_ready),
        .dn_job     (d_job),
        .dn_lat_off (d_lat_off),
        .dn_lon_off (d_lon_off)
    );

    llgi_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (d_valid),
        .up_ready   (d_ready),
        .up_job     (d_job),
        .up_lat_off (d_lat_off),
        .up_lon_off (d_lon_off),
        .dn_valid   (v_valid),
        .dn_ready   (v_ready),
        .dn_job     (v_job),
        .dn_id      (v_id)
    );

    llgi_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .up_valid    (v_valid),
        .up_ready    (v_ready),
        .up_job      (v_job),
        .up_id       (v_id),
        .dn_valid    (m_axis_tvalid),
        .dn_ready    (m_axis_tready),
        .dn_cell_id  (o_id),
        .dn_clat     (o_clat),
        .dn_clon     (o_clon),
        .dn_level    (o_level),
        .dn_adjacent (o_adj),
        .dn_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {3'd0, o_adj, o_level, o_clon, o_clat, o_id};

endmodule

[verif/tb_latlon_grid_cell_indexer.sv]
// Testbench for latlon_grid_cell_indexer: drives encode, decode, neighbor and
// adjacency commands over the stream ports and checks every result item
// against an in-bench integer predictor. Depends on llgi_pkg and the RTL.
module tb_latlon_grid_cell_indexer;
    import llgi_pkg::*;

    typedef struct {
        logic [62:0]        id;
        logic signed [55:0] clat;
        logic signed [56:0] clon;
        logic [3:0]         lvl;
        logic               adj;
        logic               last;
    } grid_res_t;

    typedef struct {
        cmd_t        cmd;
        logic [31:0] lat;
        logic [31:0] lon;
        logic [3:0]  lvl;
        logic [63:0] a;
        logic [63:0] b;
        logic        chk;
        logic [62:0] id;
    } query_t;

    localparam longint GRID_SIZE [16] = '{
        40000000, 15000000, 5000000, 1700000, 600000, 200000, 70000, 25000,
        9000, 15700, 5500, 2000, 700, 250, 90, 30
    };
    localparam longint LON_P = 64'sd3600000000;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [199:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [183:0] m_axis_tdata;
    logic         m_axis_tlast;

    grid_res_t pending_results[$];
    query_t    directed[$];
    int        error_count = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;

    latlon_grid_cell_indexer dut (.*);

    always #5 clk = ~clk;

    function automatic logic [62:0] encode_cell(longint lat, longint lon, logic [3:0] lvl);
        longint sz, k;
        logic [63:0] li, oi;
        sz = GRID_SIZE[lvl];
        if (lat > 900000000) lat = 900000000;
        if (lat < -900000000) lat = -900000000;
        if (lon > 1800000000) begin
            k = (lon - 1800000000 + LON_P - 1) / LON_P;
            lon = lon - k * LON_P;
        end else if (lon < -1800000000) begin
            k = (-1800000000 - lon + LON_P - 1) / LON_P;
            lon = lon + k * LON_P;
        end
        li = (lat + 900000000) / sz;
        oi = (lon + 1800000000) / sz;
        return {lvl, oi[29:0], li[28:0]};
    endfunction

    function automatic void cell_centre(logic [63:0] c, output longint lat, output longint lon);
        longint sz;
        sz = GRID_SIZE[c[62:59]];
        lat = longint'(c[28:0]) * sz + sz / 2 - 900000000;
        lon = longint'(c[58:29]) * sz + sz / 2 - 1800000000;
    endfunction

    task automatic add_expected(grid_res_t r);
        pending_results = {pending_results, r};
    endtask

    task automatic predict_query(query_t q);
        grid_res_t r;
        longint lat, lon, sz;
        logic [62:0] nb [8];
        int n;
        r = '{default: '0};
        r.last = 1'b1;
        if (q.cmd == CMD_ENCODE) begin
            r.id = encode_cell(longint'(signed'(q.lat)), longint'(signed'(q.lon)), q.lvl);
            r.lvl = q.lvl;
            add_expected(r);
            return;
        end
        cell_centre(q.a, lat, lon);
        r.lvl = q.a[62:59];
        if (q.cmd == CMD_DECODE) begin
            r.clat = lat[55:0];
            r.clon = lon[56:0];
            add_expected(r);
            return;
        end
        sz = GRID_SIZE[q.a[62:59]];
        n = 0;
        for (int dy = -1; dy <= 1; dy++)
            for (int dx = -1; dx <= 1; dx++)
                if (dx != 0 || dy != 0) begin
                    nb[n] = encode_cell(lat + dy * sz, lon + dx * sz, q.a[62:59]);
                    n++;
                end
        if (q.cmd == CMD_NEIGHBORS) begin
            for (int k = 0; k < 8; k++) begin
                r.id = nb[k];
                r.last = (k == 7);
                add_expected(r);
            end
        end else begin
            if (q.a != q.b)
                for (int k = 0; k < 8; k++)
                    if ({1'b0, nb[k]} == q.b) r.adj = 1'b1;
            add_expected(r);
        end
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        error_count++;
    endtask

    // returns at the falling edge after acceptance with tvalid still high
    task automatic send_query(query_t q);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= q.cmd;
        s_axis_tdata  <= {4'b0, q.b, q.a, q.lvl, q.lon, q.lat};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        predict_query(q);
        if (q.chk) pending_results[$].id = q.id;
        @(negedge clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0) @(negedge clk);
    endtask

    function automatic logic [63:0] rand_cell();
        logic [63:0] c;
        c = {$urandom, $urandom};
        if ($urandom_range(3) != 0) begin
            // keep indices on the globe most of the time
            c[28:0]  = 29'($urandom_range(1800000000 / GRID_SIZE[c[62:59]]));
            c[58:29] = 30'($urandom_range(LON_P / GRID_SIZE[c[62:59]]));
        end
        return c;
    endfunction

    function automatic query_t rand_query();
        query_t q;
        q.cmd = cmd_t'($urandom_range(3));
        q.lat = $urandom_range(1) ? $urandom : 32'($urandom_range(1800000000) - 900000000);
        q.lon = $urandom;
        q.lvl = 4'($urandom_range(15));
        q.a = rand_cell();
        q.b = rand_cell();
        q.chk = 1'b0;
        q.id = '0;
        if (q.cmd == CMD_ADJACENT) begin
            case ($urandom_range(3))
                0: q.b = q.a;
                1, 2: begin
                    q.a[63] = 1'b0;
                    q.b = {1'b0, encode_cell(0, 0, q.a[62:59])};
                    q.b[28:0] = q.a[28:0] + 29'($urandom_range(2)) - 29'd1;
                    q.b[58:29] = q.a[58:29] + 30'($urandom_range(2)) - 30'd1;
                    q.b[63] = ($urandom_range(9) == 0);
                end
                default: ;
            endcase
        end
        return q;
    endfunction

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk) begin
        grid_res_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected item", m_axis_tdata[63:0], '0);
            end else begin
                e = pending_results.pop_front();
                if (m_axis_tdata[62:0] !== e.id)
                    report_mismatch("cell_id", 64'(m_axis_tdata[62:0]), 64'(e.id));
                if (m_axis_tdata[118:63] !== e.clat)
                    report_mismatch("centre_lat", 64'(m_axis_tdata[118:63]),
                                    64'(unsigned'(e.clat)));
                if (m_axis_tdata[175:119] !== e.clon)
                    report_mismatch("centre_lon", 64'(m_axis_tdata[175:119]),
                                    64'(unsigned'(e.clon)));
                if (m_axis_tdata[179:176] !== e.lvl)
                    report_mismatch("level_out", 64'(m_axis_tdata[179:176]), 64'(e.lvl));
                if (m_axis_tdata[180] !== e.adj)
                    report_mismatch("adjacent", 64'(m_axis_tdata[180]), 64'(e.adj));
                if (m_axis_tlast !== e.last)
                    report_mismatch("tlast", 64'(m_axis_tlast), 64'(e.last));
            end
        end
    end

    initial begin
        #3000000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        query_t q;
        // cmd, lat, lon, level, cell_a, cell_b, check id, id
        directed = '{
            '{CMD_ENCODE, 32'd0, 32'd0, 4'd0, 64'd0, 64'd0, 1'b1,
              {4'd0, 30'd45, 29'd22}},
            '{CMD_ENCODE, 32'h7FFFFFFF, 32'h7FFFFFFF, 4'd15, 64'd0, 64'd0, 1'b0, 63'd0},
            '{CMD_ENCODE, 32'h80000000, 32'h80000000, 4'd15, 64'd0, 64'd0, 1'b0, 63'd0},
            '{CMD_ENCODE, -32'sd900000000, -32'sd1800000000, 4'd1, 64'd0, 64'd0, 1'b1,
              {4'd1, 30'd0, 29'd0}},
            '{CMD_ENCODE, 32'd900000000, 32'd1800000000, 4'd0, 64'd0, 64'd0, 1'b1,
              {4'd0, 30'd90, 29'd45}},
            '{CMD_ENCODE, 32'd123456789, 32'd1800000001, 4'd8, 64'd0, 64'd0, 1'b0, 63'd0},
            '{CMD_ENCODE, -32'sd5, -32'sd1800000001, 4'd9, 64'd0, 64'd0, 1'b0, 63'd0},
            '{CMD_ENCODE, 32'd1, 32'd1, 4'd7, 64'd0, 64'd0, 1'b0, 63'd0},
            '{CMD_DECODE, 32'd0, 32'd0, 4'd0, 64'd0, 64'd0, 1'b0, 63'd0},
            '{CMD_DECODE, 32'd0, 32'd0, 4'd0, 64'hFFFFFFFFFFFFFFFF, 64'd0, 1'b0, 63'd0},
            '{CMD_DECODE, 32'd0, 32'd0, 4'd0, 64'h7FFFFFFFFFFFFFFF, 64'd0, 1'b0, 63'd0},
            '{CMD_DECODE, 32'd0, 32'd0, 4'd0, {1'b0, 4'd9, 30'd1000, 29'd500}, 64'd0,
              1'b0, 63'd0},
            '{CMD_NEIGHBORS, 32'd0, 32'd0, 4'd0, 64'd0, 64'd0, 1'b0, 63'd0},
            '{CMD_NEIGHBORS, 32'd0, 32'd0, 4'd0, {1'b0, 4'd0, 30'd89, 29'd44}, 64'd0,
              1'b0, 63'd0},
            '{CMD_NEIGHBORS, 32'd0, 32'd0, 4'd0, 64'hFFFFFFFFFFFFFFFF, 64'd0, 1'b0, 63'd0},
            '{CMD_NEIGHBORS, 32'd0, 32'd0, 4'd0, {1'b0, 4'd15, 30'd5, 29'd7}, 64'd0,
              1'b0, 63'd0},
            '{CMD_ADJACENT, 32'd0, 32'd0, 4'd0, {1'b0, 4'd2, 30'd10, 29'd10},
              {1'b0, 4'd2, 30'd10, 29'd10}, 1'b0, 63'd0},
            '{CMD_ADJACENT, 32'd0, 32'd0, 4'd0, {1'b0, 4'd2, 30'd10, 29'd10},
              {1'b0, 4'd2, 30'd11, 29'd9}, 1'b0, 63'd0},
            '{CMD_ADJACENT, 32'd0, 32'd0, 4'd0, {1'b0, 4'd2, 30'd10, 29'd10},
              {1'b1, 4'd2, 30'd11, 29'd9}, 1'b0, 63'd0},
            '{CMD_ADJACENT, 32'd0, 32'd0, 4'd0, {1'b0, 4'd2, 30'd10, 29'd10},
              {1'b0, 4'd2, 30'd12, 29'd10}, 1'b0, 63'd0},
            '{CMD_ADJACENT, 32'd0, 32'd0, 4'd0, 64'hFFFFFFFFFFFFFFFF,
              64'hFFFFFFFFFFFFFFFF, 1'b0, 63'd0}
        };
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        foreach (directed[i]) send_query(directed[i]);
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 81 : 0;
            recv_idle_pct = (phase == 0) ? 81 : (phase == 1) ? 8 : 0;
            for (int n = 0; n < 150; n++) begin
                q = rand_query();
                send_query(q);
                if (n == 75)
                    drain_results();
            end
        end
        drain_results();
        repeat (40) @(negedge clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
